### src/mctm_pkg.sv
// Shared types, codes and command/status structs of the method cache tag manager.
`default_nettype none
package mctm_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned BYTES_W    = 16;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned BSL_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned SLACK_WORDS = 3;
  localparam int unsigned WORD_BYTES  = 4;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_FETCH = 2'd1,
    OP_FLUSH = 2'd2,
    OP_INIT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MISS_NONE = 2'd0,
    MISS_COLD = 2'd1,
    MISS_CAP  = 2'd2,
    MISS_TAG  = 2'd3
  } miss_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_SIZE  = 2'd1,
    ERR_FETCH = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    CFG_BLOCKS    = 2'd0,
    CFG_MAX_METH  = 2'd1,
    CFG_BLK_LOG2  = 2'd2,
    CFG_FIFO_MODE = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_SCAN, ST_SCAN_W, ST_MISS, ST_EVICT, ST_EVICT_W,
    ST_SHIFT, ST_SHIFT_W, ST_WR0, ST_FCHK, ST_FL_A, ST_FL_B, ST_FIN, ST_FIN_W
  } state_e;

  typedef enum logic [2:0] {
    RD_K, RD_K_M1, RD_HELD_M1, RD_ACT, RD_ZERO
  } rd_sel_e;

  typedef enum logic [1:0] {
    WA_K, WA_ZERO, WA_ACT
  } wa_sel_e;

  typedef enum logic {
    WD_RDATA, WD_TEMP
  } wd_sel_e;

  typedef enum logic [1:0] {
    K_KEEP, K_INC, K_DEC, K_HELD
  } k_op_e;

  typedef enum logic [1:0] {
    TL_KEEP, TL_RDATA, TL_NEW
  } temp_sel_e;

  typedef enum logic [1:0] {
    ACT_KEEP, ACT_K, ACT_ZERO
  } act_op_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [CNT_W-1:0]   blocks;
    logic [BYTES_W-1:0] bytes;
  } entry_t;

  typedef struct packed {
    logic      ld_item;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      wr_en;
    wa_sel_e   wa_sel;
    wd_sel_e   wd_sel;
    k_op_e     k_op;
    temp_sel_e temp_sel;
    act_op_e   act_op;
    logic      set_hit;
    logic      cap_ld;
    logic      evict;
    logic      commit;
    logic      err_size;
    logic      err_fetch;
    logic      fchk;
    logic      out_ld;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic k_eq_held;
    logic k_zero;
    logic base_match;
    logic need_bad;
    logic evict_more;
    logic held_zero;
    logic held_ge2;
    logic fifo;
    logic act_zero;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

### src/mctm_if.sv
// Valid/ready channel interfaces for items and results.
`default_nettype none
interface mctm_in_if;
  logic                          valid;
  logic                          ready;
  mctm_pkg::op_e                 op;
  logic [mctm_pkg::ADDR_W-1:0]   target_address;
  logic [mctm_pkg::BYTES_W-1:0]  method_bytes;
  modport source (output valid, op, target_address, method_bytes, input ready);
  modport sink   (input valid, op, target_address, method_bytes, output ready);
endinterface

interface mctm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [1:0]                   miss_kind;
  logic [mctm_pkg::CNT_W-1:0]   ev_methods;
  logic [mctm_pkg::CNT_W-1:0]   ev_blocks;
  logic [1:0]                   error_code;
  logic [mctm_pkg::ADDR_W-1:0]  active_base;
  logic [mctm_pkg::CNT_W-1:0]   active_count;
  logic [mctm_pkg::CNT_W-1:0]   blocks_used;
  modport source (output valid, hit, miss_kind, ev_methods, ev_blocks, error_code,
                  active_base, active_count, blocks_used, input ready);
  modport sink   (input valid, hit, miss_kind, ev_methods, ev_blocks, error_code,
                  active_base, active_count, blocks_used, output ready);
endinterface
`default_nettype wire

### src/mctm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mctm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

### src/mctm_ctrl.sv
// Sequencer: walks the table for lookup, eviction, entry shifting and flush.
`default_nettype none
module mctm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire mctm_pkg::sts_t sts_i,
  output      mctm_pkg::cmd_t cmd_o
);
  mctm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mctm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.rd_sel   = mctm_pkg::RD_K;
    cmd_o.wa_sel   = mctm_pkg::WA_K;
    cmd_o.wd_sel   = mctm_pkg::WD_RDATA;
    cmd_o.k_op     = mctm_pkg::K_KEEP;
    cmd_o.temp_sel = mctm_pkg::TL_KEEP;
    cmd_o.act_op   = mctm_pkg::ACT_KEEP;
    case (state_q)
      mctm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_item = 1'b1;
          state_d = mctm_pkg::ST_DISPATCH;
        end
      end
      mctm_pkg::ST_DISPATCH: begin
        case (sts_i.op)
          mctm_pkg::OP_LOAD: state_d = mctm_pkg::ST_SCAN;
          mctm_pkg::OP_FETCH: begin
            if (sts_i.held_zero) begin
              cmd_o.err_fetch = 1'b1;
              state_d = mctm_pkg::ST_FIN;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = mctm_pkg::RD_ACT;
              state_d = mctm_pkg::ST_FCHK;
            end
          end
          mctm_pkg::OP_FLUSH: begin
            if (!sts_i.held_ge2) begin
              state_d = mctm_pkg::ST_FIN;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = mctm_pkg::RD_ACT;
              state_d = mctm_pkg::ST_FL_A;
            end
          end
          default: begin
            if (sts_i.need_bad) begin
              cmd_o.err_size = 1'b1;
              state_d = mctm_pkg::ST_FIN;
            end else begin
              cmd_o.temp_sel = mctm_pkg::TL_NEW;
              state_d = mctm_pkg::ST_WR0;
            end
          end
        endcase
      end
      mctm_pkg::ST_SCAN: begin
        if (sts_i.k_eq_held) begin
          state_d = mctm_pkg::ST_MISS;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = mctm_pkg::RD_K;
          state_d = mctm_pkg::ST_SCAN_W;
        end
      end
      mctm_pkg::ST_SCAN_W: begin
        if (sts_i.base_match) begin
          cmd_o.set_hit = 1'b1;
          if (sts_i.fifo) begin
            cmd_o.act_op = mctm_pkg::ACT_K;
            state_d = mctm_pkg::ST_FIN;
          end else begin
            // LRU: pull the hit entry to the front
            cmd_o.act_op   = mctm_pkg::ACT_ZERO;
            cmd_o.temp_sel = mctm_pkg::TL_RDATA;
            state_d = mctm_pkg::ST_SHIFT;
          end
        end else begin
          cmd_o.k_op = mctm_pkg::K_INC;
          state_d = mctm_pkg::ST_SCAN;
        end
      end
      mctm_pkg::ST_MISS: begin
        if (sts_i.need_bad) begin
          cmd_o.err_size = 1'b1;
          state_d = mctm_pkg::ST_FIN;
        end else begin
          cmd_o.cap_ld = 1'b1;
          state_d = mctm_pkg::ST_EVICT;
        end
      end
      mctm_pkg::ST_EVICT: begin
        if (sts_i.evict_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = mctm_pkg::RD_HELD_M1;
          state_d = mctm_pkg::ST_EVICT_W;
        end else begin
          cmd_o.temp_sel = mctm_pkg::TL_NEW;
          cmd_o.k_op     = mctm_pkg::K_HELD;
          state_d = mctm_pkg::ST_SHIFT;
        end
      end
      mctm_pkg::ST_EVICT_W: begin
        cmd_o.evict = 1'b1;
        state_d = mctm_pkg::ST_EVICT;
      end
      mctm_pkg::ST_SHIFT: begin
        if (sts_i.k_zero) begin
          state_d = mctm_pkg::ST_WR0;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = mctm_pkg::RD_K_M1;
          state_d = mctm_pkg::ST_SHIFT_W;
        end
      end
      mctm_pkg::ST_SHIFT_W: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wa_sel = mctm_pkg::WA_K;
        cmd_o.wd_sel = mctm_pkg::WD_RDATA;
        cmd_o.k_op   = mctm_pkg::K_DEC;
        state_d = mctm_pkg::ST_SHIFT;
      end
      mctm_pkg::ST_WR0: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wa_sel = mctm_pkg::WA_ZERO;
        cmd_o.wd_sel = mctm_pkg::WD_TEMP;
        cmd_o.commit = 1'b1;
        state_d = mctm_pkg::ST_FIN;
      end
      mctm_pkg::ST_FCHK: begin
        cmd_o.fchk = 1'b1;
        state_d = mctm_pkg::ST_FIN;
      end
      mctm_pkg::ST_FL_A: begin
        // temp holds the active entry; fetch slot 0 to swap it out
        cmd_o.temp_sel = mctm_pkg::TL_RDATA;
        if (sts_i.act_zero) begin
          state_d = mctm_pkg::ST_WR0;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = mctm_pkg::RD_ZERO;
          state_d = mctm_pkg::ST_FL_B;
        end
      end
      mctm_pkg::ST_FL_B: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wa_sel = mctm_pkg::WA_ACT;
        cmd_o.wd_sel = mctm_pkg::WD_RDATA;
        state_d = mctm_pkg::ST_WR0;
      end
      mctm_pkg::ST_FIN: begin
        cmd_o.rd_en  = !sts_i.held_zero;
        cmd_o.rd_sel = mctm_pkg::RD_ACT;
        state_d = mctm_pkg::ST_FIN_W;
      end
      mctm_pkg::ST_FIN_W: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_ld = 1'b1;
          state_d = mctm_pkg::ST_IDLE;
        end
      end
      default: state_d = mctm_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### src/mctm_datapath.sv
// Table RAM, counters, size arithmetic, bound check and result register.
`default_nettype none
module mctm_datapath #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned FETCH_SLOTS   = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [mctm_pkg::CNT_W-1:0]    blocks_in_use_i,
  input  wire logic [mctm_pkg::CNT_W-1:0]    max_methods_i,
  input  wire logic [mctm_pkg::BSL_W-1:0]    block_size_log2_i,
  input  wire logic                          fifo_mode_i,
  input  wire mctm_pkg::op_e                 op_i,
  input  wire logic [mctm_pkg::ADDR_W-1:0]   target_address_i,
  input  wire logic [mctm_pkg::BYTES_W-1:0]  method_bytes_i,
  input  wire mctm_pkg::cmd_t                cmd_i,
  output      mctm_pkg::sts_t                sts_o,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic                          hit_o,
  output      logic [1:0]                    miss_kind_o,
  output      logic [mctm_pkg::CNT_W-1:0]    ev_methods_o,
  output      logic [mctm_pkg::CNT_W-1:0]    ev_blocks_o,
  output      logic [1:0]                    error_code_o,
  output      logic [mctm_pkg::ADDR_W-1:0]   active_base_o,
  output      logic [mctm_pkg::CNT_W-1:0]    active_count_o,
  output      logic [mctm_pkg::CNT_W-1:0]    blocks_used_o
);
  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned KW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned XW = (KW > mctm_pkg::CNT_W) ? KW : mctm_pkg::CNT_W;
  localparam int unsigned FW = mctm_pkg::ADDR_W + 2;
  localparam int unsigned SLACK = mctm_pkg::WORD_BYTES * FETCH_SLOTS * mctm_pkg::SLACK_WORDS;
  localparam int unsigned NW = mctm_pkg::BYTES_W + 1;

  mctm_pkg::op_e                op_q;
  logic [mctm_pkg::ADDR_W-1:0]  addr_q;
  logic [mctm_pkg::BYTES_W-1:0] bytes_q;
  logic [mctm_pkg::CNT_W-1:0]   held_q, hblk_q, evm_q, evb_q;
  logic [IW-1:0]                act_q;
  logic [KW-1:0]                k_q;
  mctm_pkg::entry_t             temp_q, rdata;
  logic                         hit_q, cap_q;
  logic [1:0]                   kind_q, err_q;

  // size to blocks
  logic [NW-1:0]              need_w;
  logic [mctm_pkg::CNT_W-1:0] need;
  logic                       need_bad;
  assign need_w   = ((NW'(bytes_q) - NW'(1)) >> block_size_log2_i) + NW'(1);
  assign need     = need_w[mctm_pkg::CNT_W-1:0];
  assign need_bad = (bytes_q == '0) || (need_w > NW'(blocks_in_use_i));

  logic [mctm_pkg::CNT_W:0]   hsum;
  logic [mctm_pkg::CNT_W-1:0] lim_m;
  logic [XW-1:0]              lim;
  logic                       evict_more;
  assign hsum  = (mctm_pkg::CNT_W+1)'(hblk_q) + (mctm_pkg::CNT_W+1)'(need);
  assign lim_m = (max_methods_i != '0) ? max_methods_i : blocks_in_use_i;
  assign lim   = (XW'(lim_m) > XW'(TABLE_ENTRIES)) ? XW'(TABLE_ENTRIES) : XW'(lim_m);
  assign evict_more = (held_q != '0) &&
                      ((hsum > (mctm_pkg::CNT_W+1)'(blocks_in_use_i)) || (XW'(held_q) >= lim));

  logic [IW-1:0] act_raw, act_idx;
  assign act_raw = fifo_mode_i ? act_q : '0;
  assign act_idx = (XW'(act_raw) < XW'(held_q)) ? act_raw : '0;

  // table RAM
  logic [IW-1:0]    raddr, waddr;
  mctm_pkg::entry_t wdata;
  always_comb begin
    case (cmd_i.rd_sel)
      mctm_pkg::RD_K:       raddr = IW'(k_q);
      mctm_pkg::RD_K_M1:    raddr = IW'(k_q - KW'(1));
      mctm_pkg::RD_HELD_M1: raddr = IW'(held_q - mctm_pkg::CNT_W'(1));
      mctm_pkg::RD_ACT:     raddr = act_idx;
      default:              raddr = '0;
    endcase
    case (cmd_i.wa_sel)
      mctm_pkg::WA_K:   waddr = IW'(k_q);
      mctm_pkg::WA_ACT: waddr = act_idx;
      default:          waddr = '0;
    endcase
    wdata = (cmd_i.wd_sel == mctm_pkg::WD_TEMP) ? temp_q : rdata;
  end

  mctm_ram #(
    .WIDTH($bits(mctm_pkg::entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // fetch bounds, no wraparound
  logic [FW-1:0] lo, hi, fa;
  assign lo = FW'(rdata.base);
  assign hi = lo + FW'(rdata.bytes) + FW'(SLACK);
  assign fa = FW'(addr_q);

  // payload-only registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      op_q    <= op_i;
      addr_q  <= target_address_i;
      bytes_q <= method_bytes_i;
    end
    case (cmd_i.temp_sel)
      mctm_pkg::TL_RDATA: temp_q <= rdata;
      mctm_pkg::TL_NEW:   temp_q <= '{base: addr_q, blocks: need, bytes: bytes_q};
      default:            temp_q <= temp_q;
    endcase
    if (cmd_i.cap_ld) begin
      cap_q <= hsum > (mctm_pkg::CNT_W+1)'(blocks_in_use_i);
    end
    if (cmd_i.out_ld) begin
      hit_o         <= hit_q;
      miss_kind_o   <= kind_q;
      ev_methods_o  <= evm_q;
      ev_blocks_o   <= evb_q;
      error_code_o  <= err_q;
      active_base_o <= (held_q == '0) ? '0 : rdata.base;
      active_count_o <= held_q;
      blocks_used_o <= hblk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      hblk_q      <= '0;
      act_q       <= '0;
      k_q         <= '0;
      evm_q       <= '0;
      evb_q       <= '0;
      hit_q       <= 1'b0;
      kind_q      <= mctm_pkg::MISS_NONE;
      err_q       <= mctm_pkg::ERR_NONE;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.ld_item) begin
        k_q    <= '0;
        evm_q  <= '0;
        evb_q  <= '0;
        hit_q  <= 1'b0;
        kind_q <= mctm_pkg::MISS_NONE;
        err_q  <= mctm_pkg::ERR_NONE;
      end
      case (cmd_i.k_op)
        mctm_pkg::K_INC:  k_q <= k_q + KW'(1);
        mctm_pkg::K_DEC:  k_q <= k_q - KW'(1);
        mctm_pkg::K_HELD: k_q <= KW'(held_q);
        default: ;
      endcase
      case (cmd_i.act_op)
        mctm_pkg::ACT_K:    act_q <= IW'(k_q);
        mctm_pkg::ACT_ZERO: act_q <= '0;
        default: ;
      endcase
      if (cmd_i.set_hit) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.err_size) begin
        err_q <= mctm_pkg::ERR_SIZE;
      end
      if (cmd_i.err_fetch || (cmd_i.fchk && ((fa < lo) || (hi <= fa)))) begin
        err_q <= mctm_pkg::ERR_FETCH;
      end
      if (cmd_i.evict) begin
        evm_q  <= evm_q + mctm_pkg::CNT_W'(1);
        evb_q  <= evb_q + rdata.blocks;
        hblk_q <= (hblk_q >= rdata.blocks) ? hblk_q - rdata.blocks : '0;
        held_q <= held_q - mctm_pkg::CNT_W'(1);
      end
      if (cmd_i.commit) begin
        case (op_q)
          mctm_pkg::OP_LOAD: begin
            if (!hit_q) begin
              held_q <= held_q + mctm_pkg::CNT_W'(1);
              hblk_q <= hblk_q + need;
              act_q  <= '0;
              kind_q <= (evm_q == '0) ? mctm_pkg::MISS_COLD :
                        (cap_q ? mctm_pkg::MISS_CAP : mctm_pkg::MISS_TAG);
            end
          end
          mctm_pkg::OP_FLUSH: begin
            held_q <= mctm_pkg::CNT_W'(1);
            hblk_q <= temp_q.blocks;
            act_q  <= '0;
          end
          mctm_pkg::OP_INIT: begin
            held_q <= mctm_pkg::CNT_W'(1);
            hblk_q <= need;
            act_q  <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.out_ld) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.k_eq_held  = XW'(k_q) == XW'(held_q);
  assign sts_o.k_zero     = k_q == '0;
  assign sts_o.base_match = rdata.base == addr_q;
  assign sts_o.need_bad   = need_bad;
  assign sts_o.evict_more = evict_more;
  assign sts_o.held_zero  = held_q == '0;
  assign sts_o.held_ge2   = held_q >= mctm_pkg::CNT_W'(2);
  assign sts_o.fifo       = fifo_mode_i;
  assign sts_o.act_zero   = act_idx == '0;
  assign sts_o.out_busy   = out_valid_o && !out_ready_i;
endmodule
`default_nettype wire

### src/method_cache_tag_manager.sv
// Top level of the method cache tag manager: config registers, sequencer, datapath.
// Usage:
//   in_if  : one transfer per operation (load method, fetch check, flush, initialize).
//   out_if : exactly one result transfer per accepted operation, in order.
//   cfg    : cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0 blocks in use,
//            1 max methods, 2 log2 block bytes, 3 FIFO mode); write only while idle.
// Sequence: a load scans the table from slot 0; a miss evicts from the tail, shifts
//   the held entries down and writes the new one to slot 0; an LRU hit shifts the
//   hit entry to the front. The sequencer returns to idle before it takes the next
//   transfer.
// One operation is handled at a time; in_if.ready is high only when the sequencer
// is idle. A finished result sits in the output register, so the next operation
// is taken while it waits; the sequencer then holds its own result until out_if
// frees. Reset empties the table (count and block total cleared), restores
// register defaults and drops any pending result. Table contents are not cleared.
`default_nettype none
module method_cache_tag_manager #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned FETCH_SLOTS   = 2
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [mctm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [mctm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  mctm_in_if.sink                                in_if,
  mctm_out_if.source                             out_if
);
  logic [mctm_pkg::CNT_W-1:0] blocks_in_use_q, max_methods_q;
  logic [mctm_pkg::BSL_W-1:0] block_size_log2_q;
  logic                       fifo_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_in_use_q   <= mctm_pkg::CNT_W'(16);
      max_methods_q     <= mctm_pkg::CNT_W'(16);
      block_size_log2_q <= mctm_pkg::BSL_W'(5);
      fifo_mode_q       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mctm_pkg::CFG_BLOCKS:   blocks_in_use_q   <= cfg_wdata_i[mctm_pkg::CNT_W-1:0];
        mctm_pkg::CFG_MAX_METH: max_methods_q     <= cfg_wdata_i[mctm_pkg::CNT_W-1:0];
        mctm_pkg::CFG_BLK_LOG2: block_size_log2_q <= cfg_wdata_i[mctm_pkg::BSL_W-1:0];
        default:                fifo_mode_q       <= cfg_wdata_i[0];
      endcase
    end
  end

  mctm_pkg::cmd_t cmd;
  mctm_pkg::sts_t sts;

  mctm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mctm_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FETCH_SLOTS   (FETCH_SLOTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .blocks_in_use_i   (blocks_in_use_q),
    .max_methods_i     (max_methods_q),
    .block_size_log2_i (block_size_log2_q),
    .fifo_mode_i       (fifo_mode_q),
    .op_i              (in_if.op),
    .target_address_i  (in_if.target_address),
    .method_bytes_i    (in_if.method_bytes),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_if.valid),
    .out_ready_i       (out_if.ready),
    .hit_o             (out_if.hit),
    .miss_kind_o       (out_if.miss_kind),
    .ev_methods_o      (out_if.ev_methods),
    .ev_blocks_o       (out_if.ev_blocks),
    .error_code_o      (out_if.error_code),
    .active_base_o     (out_if.active_base),
    .active_count_o    (out_if.active_count),
    .blocks_used_o     (out_if.blocks_used)
  );

  // table occupancy never exceeds its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (32'(out_if.active_count) <= TABLE_ENTRIES))
    else $error("active_count beyond table depth");

  // a hit never reports a miss kind or evictions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.hit) |->
      (out_if.miss_kind == mctm_pkg::MISS_NONE && out_if.ev_methods == '0))
    else $error("hit with miss information");

  // evictions imply a capacity or tag-count miss
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ev_methods != '0) |->
      (out_if.miss_kind == mctm_pkg::MISS_CAP || out_if.miss_kind == mctm_pkg::MISS_TAG))
    else $error("evictions without matching miss kind");
endmodule
`default_nettype wire

### bench/tb_method_cache_tag_manager.sv
// Self-checking testbench of the method cache tag manager: directed table, then random phases.
`timescale 1ns / 100ps
module tb_method_cache_tag_manager;

  typedef struct packed {
    logic            hit;
    mctm_pkg::miss_e miss_kind;
    logic [4:0]      ev_methods;
    logic [4:0]      ev_blocks;
    mctm_pkg::err_e  err;
    logic [31:0]     base;
    logic [4:0]      count;
    logic [4:0]      blocks;
  } status_t;

  typedef struct packed {
    mctm_pkg::op_e op;
    logic [31:0]   addr;
    logic [15:0]   nbytes;
    logic          typed;
    status_t       want;
  } cmd_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [mctm_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [mctm_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  mctm_in_if  in_ch ();
  mctm_out_if out_ch ();

  method_cache_tag_manager dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .in_if(in_ch), .out_if(out_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = mctm_pkg::OP_LOAD;
    in_ch.target_address = '0;
    in_ch.method_bytes = '0;
    out_ch.ready = 1'b0;
  end

  // shadow of the tag table and registers
  logic [31:0] tag_base [16];
  int          tag_blocks [16];
  int          tag_bytes [16];
  int held_cnt = 0, held_blk = 0, act_slot = 0;
  int blk_avail = 16, meth_max = 16, blk_log2 = 5, fifo_on = 0;

  cmd_row_t send_q[$];
  status_t  status_q[$];
  int  idle_mode = 0;
  bit  failed = 0;
  logic [31:0] base_pool [20];

  function automatic int active_idx();
    int a;
    a = fifo_on ? act_slot : 0;
    return (a < held_cnt) ? a : 0;
  endfunction

  function automatic void move_tag(int to, int from);
    tag_base[to] = tag_base[from];
    tag_blocks[to] = tag_blocks[from];
    tag_bytes[to] = tag_bytes[from];
  endfunction

  function automatic status_t cache_predict(mctm_pkg::op_e op, logic [31:0] addr,
                                            logic [15:0] nb);
    status_t r;
    int k, j, need, lim, em, eb, v, a, tb, tk, ty;
    bit found, capacity;
    logic [63:0] lo, hi;
    logic [31:0] tbase;
    em = 0; eb = 0; found = 0;
    r = '0;
    case (op)
      mctm_pkg::OP_LOAD: begin
        for (k = 0; k < held_cnt; k++) if (tag_base[k] == addr) begin
          found = 1;
          break;
        end
        if (found) begin
          r.hit = 1'b1;
          if (fifo_on) act_slot = k;
          else begin
            tbase = tag_base[k]; tk = tag_blocks[k]; ty = tag_bytes[k];
            for (j = k; j > 0; j--) move_tag(j, j - 1);
            tag_base[0] = tbase; tag_blocks[0] = tk; tag_bytes[0] = ty;
            act_slot = 0;
          end
        end else begin
          need = (nb == 0) ? 0 : ((int'(nb) - 1) >> blk_log2) + 1;
          if (need == 0 || need > blk_avail) r.err = mctm_pkg::ERR_SIZE;
          else begin
            lim = meth_max ? meth_max : blk_avail;
            if (lim > 16) lim = 16;
            capacity = held_blk + need > blk_avail;
            while (held_cnt > 0 && (held_blk + need > blk_avail || held_cnt >= lim)) begin
              v = held_cnt - 1;
              eb += tag_blocks[v];
              em++;
              held_blk = (held_blk >= tag_blocks[v]) ? held_blk - tag_blocks[v] : 0;
              held_cnt--;
            end
            if (held_cnt >= 16) held_cnt = 15;
            for (j = held_cnt; j > 0; j--) move_tag(j, j - 1);
            tag_base[0] = addr; tag_blocks[0] = need; tag_bytes[0] = int'(nb);
            held_cnt++;
            held_blk += need;
            act_slot = 0;
            r.miss_kind = (em == 0) ? mctm_pkg::MISS_COLD :
                          (capacity ? mctm_pkg::MISS_CAP : mctm_pkg::MISS_TAG);
          end
        end
      end
      mctm_pkg::OP_FETCH: begin
        if (held_cnt == 0) r.err = mctm_pkg::ERR_FETCH;
        else begin
          a = active_idx();
          lo = 64'(tag_base[a]);
          hi = lo + 64'(tag_bytes[a]) + 64'd24;
          if (64'(addr) < lo || hi <= 64'(addr)) r.err = mctm_pkg::ERR_FETCH;
        end
      end
      mctm_pkg::OP_FLUSH: begin
        if (held_cnt >= 2) begin
          a = active_idx();
          if (a != 0) begin
            tbase = tag_base[a]; tb = tag_blocks[a]; ty = tag_bytes[a];
            move_tag(a, 0);
            tag_base[0] = tbase; tag_blocks[0] = tb; tag_bytes[0] = ty;
          end
          act_slot = 0;
          held_cnt = 1;
          held_blk = tag_blocks[0];
        end
      end
      default: begin
        need = (nb == 0) ? 0 : ((int'(nb) - 1) >> blk_log2) + 1;
        if (need == 0 || need > blk_avail) r.err = mctm_pkg::ERR_SIZE;
        else begin
          tag_base[0] = addr; tag_blocks[0] = need; tag_bytes[0] = int'(nb);
          held_cnt = 1;
          held_blk = need;
          act_slot = 0;
        end
      end
    endcase
    r.ev_methods = em[4:0];
    r.ev_blocks = eb[4:0];
    r.base = held_cnt ? tag_base[active_idx()] : '0;
    r.count = held_cnt[4:0];
    r.blocks = held_blk[4:0];
    return r;
  endfunction

  function automatic bit stall_draw(bit sender);
    int pct;
    if (idle_mode == 2) return 0;
    pct = ((idle_mode == 0) == sender) ? 23 : 74;
    return $urandom_range(0, 99) < pct;
  endfunction

  // sender: present queued commands, predict each transfer
  always @(posedge clk_i) begin
    status_t p;
    if (in_ch.valid && in_ch.ready) begin
      p = cache_predict(in_ch.op, in_ch.target_address, in_ch.method_bytes);
      status_q.push_back(send_q[0].typed ? send_q[0].want : p);
      void'(send_q.pop_front());
    end
    if (!in_ch.valid || in_ch.ready) begin
      if (rst_ni && send_q.size() > 0 && !stall_draw(1)) begin
        in_ch.valid <= 1'b1;
        in_ch.op <= send_q[0].op;
        in_ch.target_address <= send_q[0].addr;
        in_ch.method_bytes <= send_q[0].nbytes;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    status_t w;
    if (out_ch.valid && out_ch.ready) begin
      if (status_q.size() == 0) begin
        $error("result with nothing expected");
        failed = 1;
      end else begin
        w = status_q.pop_front();
        if (out_ch.hit !== w.hit) begin
          $error("hit: expected %0d actual %0d", w.hit, out_ch.hit); failed = 1;
        end
        if (out_ch.miss_kind !== w.miss_kind) begin
          $error("miss_kind: expected %0d actual %0d", w.miss_kind, out_ch.miss_kind);
          failed = 1;
        end
        if (out_ch.ev_methods !== w.ev_methods) begin
          $error("ev_methods: expected %0d actual %0d", w.ev_methods,
                 out_ch.ev_methods);
          failed = 1;
        end
        if (out_ch.ev_blocks !== w.ev_blocks) begin
          $error("ev_blocks: expected %0d actual %0d", w.ev_blocks,
                 out_ch.ev_blocks);
          failed = 1;
        end
        if (out_ch.error_code !== w.err) begin
          $error("error_code: expected %0d actual %0d", w.err, out_ch.error_code);
          failed = 1;
        end
        if (out_ch.active_base !== w.base) begin
          $error("active_base: expected %h actual %h", w.base, out_ch.active_base);
          failed = 1;
        end
        if (out_ch.active_count !== w.count) begin
          $error("active_count: expected %0d actual %0d", w.count, out_ch.active_count);
          failed = 1;
        end
        if (out_ch.blocks_used !== w.blocks) begin
          $error("blocks_used: expected %0d actual %0d", w.blocks, out_ch.blocks_used);
          failed = 1;
        end
      end
    end
    out_ch.ready <= rst_ni && !stall_draw(0);
  end

  task automatic write_reg(mctm_pkg::cfg_idx_e idx, int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[mctm_pkg::CFG_DATA_W-1:0];
    case (idx)
      mctm_pkg::CFG_BLOCKS:   blk_avail = val & 31;
      mctm_pkg::CFG_MAX_METH: meth_max = val & 31;
      mctm_pkg::CFG_BLK_LOG2: blk_log2 = val & 15;
      default:                fifo_on = val & 1;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (send_q.size() != 0 || in_ch.valid || status_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic cmd_row_t random_cmd();
    cmd_row_t c;
    int pick, a, span;
    c = '0;
    pick = $urandom_range(0, 99);
    span = blk_avail << blk_log2;
    if (span > 65535) span = 65535;
    c.addr = base_pool[$urandom_range(0, 19)];
    if ($urandom_range(0, 2) == 0) c.nbytes = 16'($urandom_range(1, 1 << blk_log2));
    else c.nbytes = 16'($urandom_range(1, span));
    if ($urandom_range(0, 24) == 0) c.nbytes = 16'd0;
    else if ($urandom_range(0, 24) == 0) c.nbytes = 16'($urandom);
    if (pick < 50) c.op = mctm_pkg::OP_LOAD;
    else if (pick < 80) begin
      c.op = mctm_pkg::OP_FETCH;
      if (held_cnt > 0) begin
        a = active_idx();
        c.addr = tag_base[a] + $urandom_range(0, tag_bytes[a] + 30);
        if ($urandom_range(0, 9) == 0) c.addr = tag_base[a] - 1;
      end
    end else if (pick < 87) c.op = mctm_pkg::OP_FLUSH;
    else if (pick < 92) c.op = mctm_pkg::OP_INIT;
    else begin
      c.op = mctm_pkg::op_e'($urandom_range(0, 3));
      c.addr = $urandom;
    end
    return c;
  endfunction

  localparam int N_DIR = 17;
  cmd_row_t dir_tbl [N_DIR];
  int cfg_tbl [9][4] = '{
    '{16, 16, 5, 0}, '{16, 16, 5, 1}, '{1, 1, 2, 0}, '{1, 16, 10, 1}, '{4, 2, 3, 0},
    '{16, 3, 2, 1}, '{8, 16, 4, 0}, '{16, 1, 10, 0}, '{3, 16, 2, 1}
  };

  initial begin
    dir_tbl = '{
      '{mctm_pkg::OP_FETCH, 32'h0, 16'd0, 1'b1,
        '{1'b0, mctm_pkg::MISS_NONE, 5'd0, 5'd0, mctm_pkg::ERR_FETCH, 32'h0, 5'd0, 5'd0}},
      '{mctm_pkg::OP_FLUSH, 32'h0, 16'd0, 1'b1,
        '{1'b0, mctm_pkg::MISS_NONE, 5'd0, 5'd0, mctm_pkg::ERR_NONE, 32'h0, 5'd0, 5'd0}},
      '{mctm_pkg::OP_LOAD, 32'h100, 16'd0, 1'b1,
        '{1'b0, mctm_pkg::MISS_NONE, 5'd0, 5'd0, mctm_pkg::ERR_SIZE, 32'h0, 5'd0, 5'd0}},
      '{mctm_pkg::OP_LOAD, 32'h100, 16'd513, 1'b1,
        '{1'b0, mctm_pkg::MISS_NONE, 5'd0, 5'd0, mctm_pkg::ERR_SIZE, 32'h0, 5'd0, 5'd0}},
      '{mctm_pkg::OP_LOAD, 32'h100, 16'd1, 1'b1,
        '{1'b0, mctm_pkg::MISS_COLD, 5'd0, 5'd0, mctm_pkg::ERR_NONE, 32'h100, 5'd1, 5'd1}},
      '{mctm_pkg::OP_FETCH, 32'h100, 16'd0, 1'b0, '0},
      '{mctm_pkg::OP_FETCH, 32'h119, 16'd0, 1'b0, '0},
      '{mctm_pkg::OP_FETCH, 32'hFF, 16'd0, 1'b0, '0},
      '{mctm_pkg::OP_LOAD, 32'h200, 16'd512, 1'b0, '0},
      '{mctm_pkg::OP_LOAD, 32'h100, 16'd32, 1'b0, '0},
      '{mctm_pkg::OP_LOAD, 32'h300, 16'd32, 1'b0, '0},
      '{mctm_pkg::OP_LOAD, 32'h100, 16'd7, 1'b0, '0},
      '{mctm_pkg::OP_FLUSH, 32'h0, 16'd0, 1'b0, '0},
      '{mctm_pkg::OP_INIT, 32'hFFFFFFFF, 16'hFFFF, 1'b0, '0},
      '{mctm_pkg::OP_INIT, 32'hFFFFFFE0, 16'd16, 1'b0, '0},
      '{mctm_pkg::OP_FETCH, 32'hFFFFFFFF, 16'd0, 1'b0, '0},
      '{mctm_pkg::OP_LOAD, 32'h0, 16'd1, 1'b0, '0}
    };
    base_pool[0] = 32'h0;
    base_pool[1] = 32'hFFFFFF00;
    for (int i = 2; i < 20; i++) base_pool[i] = $urandom & 32'hFFFFFFFC;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < N_DIR; i++) send_q.push_back(dir_tbl[i]);
    drain();
    for (int ph = 0; ph < 9; ph++) begin
      idle_mode = ph / 3;
      write_reg(mctm_pkg::CFG_BLOCKS, cfg_tbl[ph][0]);
      write_reg(mctm_pkg::CFG_MAX_METH, cfg_tbl[ph][1]);
      write_reg(mctm_pkg::CFG_BLK_LOG2, cfg_tbl[ph][2]);
      write_reg(mctm_pkg::CFG_FIFO_MODE, cfg_tbl[ph][3]);
      for (int n = 0; n < 172; n++) begin
        while (send_q.size() >= 2) @(posedge clk_i);
        send_q.push_back(random_cmd());
        // hold off mid-phase until every result is back
        if (n == 86) drain();
      end
      drain();
    end
    repeat (100) @(posedge clk_i);
    if (!failed && status_q.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
